// ===== rtl/tle_pkg.sv =====
// Shared types and constants for the terminal line editor with history.
`timescale 1ns / 1ps

package tle_pkg;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_CSI  = 8'h5B;
  localparam logic [7:0] CH_UP   = 8'h41;
  localparam logic [7:0] CH_DOWN = 8'h42;
  localparam logic [7:0] CH_NUL  = 8'h00;

  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_ERASE  = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TAKE = 1'b1;
  localparam logic CFG_ECHO  = 1'b0;
  localparam logic CFG_ERASE = 1'b1;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_CRD  = 12'b000000000010,
    S_CWR  = 12'b000000000100,
    S_CR   = 12'b000000001000,
    S_LF   = 12'b000000010000,
    S_ONE  = 12'b000000100000,
    S_RLEN = 12'b000001000000,
    S_RERS = 12'b000010000000,
    S_RRD  = 12'b000100000000,
    S_REM  = 12'b001000000000,
    S_TRD  = 12'b010000000000,
    S_TEM  = 12'b100000000000
  } tle_state_t;

  typedef struct packed {
    logic edit_we;
    logic taken_we;
    logic hist_we;
    logic len_we;
  } tle_we_t;

endpackage

// ===== rtl/tle_store.sv =====
// Line, taken-line, history byte and history length memories.
`timescale 1ns / 1ps

module tle_store import tle_pkg::*; #(
  parameter int LINE_BYTES    = 64,
  parameter int HISTORY_DEPTH = 8,
  parameter int LW            = 6,
  parameter int HW            = 3
) (
  input  logic          clk,
  input  tle_we_t       we,
  input  logic [LW-1:0] waddr,
  input  logic [HW-1:0] wslot,
  input  logic [7:0]    wdata,
  input  logic [LW-1:0] wlen,
  input  logic [LW-1:0] raddr,
  input  logic [HW-1:0] rslot,
  output logic [7:0]    edit_q,
  output logic [7:0]    taken_q,
  output logic [7:0]    hist_q,
  output logic [LW-1:0] len_q
);

  localparam int HDEPTH = HISTORY_DEPTH * LINE_BYTES;
  localparam int AW     = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

  logic [7:0]    edit_mem  [LINE_BYTES];
  logic [7:0]    taken_mem [LINE_BYTES];
  logic [7:0]    hist_mem  [HDEPTH];
  logic [LW-1:0] len_mem   [HISTORY_DEPTH];

  logic [AW-1:0] hist_wa;
  logic [AW-1:0] hist_ra;

  assign hist_wa = AW'(AW'(wslot) * AW'(LINE_BYTES)) + AW'(waddr);
  assign hist_ra = AW'(AW'(rslot) * AW'(LINE_BYTES)) + AW'(raddr);

  always_ff @(posedge clk) begin
    if (we.edit_we) begin
      edit_mem[waddr] <= wdata;
    end
    if (we.taken_we) begin
      taken_mem[waddr] <= wdata;
    end
    if (we.hist_we) begin
      hist_mem[hist_wa] <= wdata;
    end
    if (we.len_we) begin
      len_mem[wslot] <= wlen;
    end
    edit_q  <= edit_mem[raddr];
    taken_q <= taken_mem[raddr];
    hist_q  <= hist_mem[hist_ra];
    len_q   <= len_mem[rslot];
  end

endmodule

// ===== rtl/terminal_line_editor_history_unit.sv =====
// Top level: line editor sequencer, history ring control and result register.
`timescale 1ns / 1ps

// Usage:
// Input transactions carry a command (received byte or take) and a byte on
// in_valid/in_stall. Results leave on out_valid/out_stall, one per transaction,
// with out_last on the final result of each input; an input may give none.
// cfg_we/cfg_index/cfg_data write echo_enable (0) and erase_enable (1).
// A commit copies the edit line into the taken line up to its first NUL
// byte, unless a taken line is still pending, then echoes CR LF if echo is on.
// A recall reads the history length, then erases the old line if echo is on
// and moves the history bytes into the edit line; a take emits the status,
// then the taken line byte by byte. in_stall is high while an item is in
// work. A stalled receiver holds the result register and the loop waits.
// Reset clears all control state; line and history memories are not cleared
// and are read only where written.
module terminal_line_editor_history_unit import tle_pkg::*; #(
  parameter int LINE_BYTES    = 64,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [5:0] out_run_count,
  output logic       out_line_ready,
  output logic       out_line_overflow,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data
);

  localparam int LW = $clog2(LINE_BYTES);
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int IW = HW + 2;
  localparam logic [LW-1:0] LMAX = LW'(LINE_BYTES - 1);
  localparam logic [HW-1:0] SMAX = HW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] FMAX = FW'(HISTORY_DEPTH);
  localparam logic [IW-1:0] HDI  = IW'(HISTORY_DEPTH);

  tle_state_t    state_r, state_nxt;
  logic [1:0]    esc_r, esc_nxt;
  logic [LW-1:0] edit_len_r, edit_len_nxt;
  logic [LW-1:0] taken_len_r, taken_len_nxt;
  logic          ready_r, ready_nxt;
  logic          ovf_r, ovf_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [HW-1:0] wslot_r, wslot_nxt;
  logic          rec_act_r, rec_act_nxt;
  logic [HW-1:0] rec_pos_r, rec_pos_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] lim_r, lim_nxt;
  logic [LW-1:0] old_r, old_nxt;
  logic [HW-1:0] idx_r, idx_nxt;
  logic          more_r, more_nxt;
  logic          push_r, push_nxt;
  logic          echo_r, erase_r;

  logic [1:0] hold_kind_r, hold_kind_nxt;
  logic [7:0] hold_data_r, hold_data_nxt;
  logic [5:0] hold_cnt_r, hold_cnt_nxt;
  logic       hold_rdy_r, hold_rdy_nxt;
  logic       hold_ovf_r, hold_ovf_nxt;
  logic       hold_last_r, hold_last_nxt;

  logic       out_valid_r;
  logic [1:0] out_kind_r;
  logic [7:0] out_data_r;
  logic [5:0] out_cnt_r;
  logic       out_rdy_r, out_ovf_r, out_last_r;

  logic       em;
  logic [1:0] em_kind;
  logic [7:0] em_data;
  logic [5:0] em_cnt;
  logic       em_rdy, em_ovf, em_last;
  logic       can_emit, accept;

  tle_we_t       we;
  logic [LW-1:0] waddr, raddr;
  logic [HW-1:0] wslot, rslot;
  logic [7:0]    wdata;
  logic [7:0]    edit_q, taken_q, hist_q;
  logic [LW-1:0] len_q;
  logic [IW-1:0] idx_t0, idx_t1, idx_t2;
  logic [HW-1:0] idx_c;

  assign can_emit = !out_valid_r || !out_stall;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign idx_t0 = IW'(wslot_r) + IW'(2 * HISTORY_DEPTH - 1) - IW'(rec_pos_r);
  assign idx_t1 = (idx_t0 >= HDI) ? idx_t0 - HDI : idx_t0;
  assign idx_t2 = (idx_t1 >= HDI) ? idx_t1 - HDI : idx_t1;
  assign idx_c  = HW'(idx_t2);

  tle_store #(
    .LINE_BYTES    (LINE_BYTES),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .LW            (LW),
    .HW            (HW)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wslot   (wslot),
    .wdata   (wdata),
    .wlen    (taken_len_r),
    .raddr   (raddr),
    .rslot   (rslot),
    .edit_q  (edit_q),
    .taken_q (taken_q),
    .hist_q  (hist_q),
    .len_q   (len_q)
  );

  always_comb begin
    state_nxt     = state_r;
    esc_nxt       = esc_r;
    edit_len_nxt  = edit_len_r;
    taken_len_nxt = taken_len_r;
    ready_nxt     = ready_r;
    ovf_nxt       = ovf_r;
    fill_nxt      = fill_r;
    wslot_nxt     = wslot_r;
    rec_act_nxt   = rec_act_r;
    rec_pos_nxt   = rec_pos_r;
    cnt_nxt       = cnt_r;
    lim_nxt       = lim_r;
    old_nxt       = old_r;
    idx_nxt       = idx_r;
    more_nxt      = more_r;
    push_nxt      = push_r;
    hold_kind_nxt = hold_kind_r;
    hold_data_nxt = hold_data_r;
    hold_cnt_nxt  = hold_cnt_r;
    hold_rdy_nxt  = hold_rdy_r;
    hold_ovf_nxt  = hold_ovf_r;
    hold_last_nxt = hold_last_r;
    em      = 1'b0;
    em_kind = KIND_ECHO;
    em_data = CH_NUL;
    em_cnt  = 6'd0;
    em_rdy  = 1'b0;
    em_ovf  = 1'b0;
    em_last = 1'b0;
    we      = '0;
    waddr   = cnt_r;
    wslot   = idx_r;
    wdata   = in_rx_byte;
    raddr   = cnt_r;
    rslot   = idx_r;

    unique case (state_r)
      S_IDLE: begin
        waddr = edit_len_r;
        wslot = wslot_r;
        if (accept) begin
          if (in_command != CMD_BYTE) begin
            hold_kind_nxt = KIND_STATUS;
            hold_data_nxt = CH_NUL;
            hold_cnt_nxt  = ready_r ? 6'(taken_len_r) : 6'd0;
            hold_rdy_nxt  = ready_r;
            hold_ovf_nxt  = ovf_r;
            hold_last_nxt = !ready_r || (taken_len_r == '0);
            more_nxt      = ready_r && (taken_len_r != '0);
            cnt_nxt       = '0;
            lim_nxt       = taken_len_r;
            idx_nxt       = wslot_r;
            push_nxt      = !ovf_r;
            state_nxt     = S_ONE;
            if (ready_r) begin
              ready_nxt = 1'b0;
              if (ovf_r) begin
                ovf_nxt = 1'b0;
              end else if (taken_len_r != '0) begin
                we.len_we   = 1'b1;
                wslot_nxt   = (wslot_r == SMAX) ? '0 : wslot_r + 1'b1;
                fill_nxt    = (fill_r == FMAX) ? fill_r : fill_r + 1'b1;
                rec_act_nxt = 1'b0;
              end
            end
          end else if (esc_r == ESC_SEEN) begin
            esc_nxt = (in_rx_byte == CH_CSI) ? ESC_CSI : ESC_NONE;
          end else if (esc_r == ESC_CSI) begin
            esc_nxt = ESC_NONE;
            old_nxt = edit_len_r;
            if (in_rx_byte == CH_UP && fill_r != '0) begin
              if (!rec_act_r) begin
                rec_act_nxt = 1'b1;
                rec_pos_nxt = '0;
              end else if (FW'(rec_pos_r) < fill_r - 1'b1) begin
                rec_pos_nxt = rec_pos_r + 1'b1;
              end
              state_nxt = S_RLEN;
            end else if (in_rx_byte == CH_DOWN && fill_r != '0) begin
              if (!rec_act_r || rec_pos_r == '0) begin
                rec_act_nxt  = 1'b0;
                edit_len_nxt = '0;
                if (echo_r && edit_len_r != '0) begin
                  hold_kind_nxt = KIND_ERASE;
                  hold_data_nxt = CH_NUL;
                  hold_cnt_nxt  = 6'(edit_len_r);
                  hold_rdy_nxt  = 1'b0;
                  hold_ovf_nxt  = 1'b0;
                  hold_last_nxt = 1'b1;
                  more_nxt      = 1'b0;
                  state_nxt     = S_ONE;
                end
              end else begin
                rec_pos_nxt = rec_pos_r - 1'b1;
                state_nxt   = S_RLEN;
              end
            end
          end else if (in_rx_byte == CH_ESC) begin
            esc_nxt = ESC_SEEN;
          end else if (in_rx_byte == CH_CR || in_rx_byte == CH_LF) begin
            if (!ready_r) begin
              cnt_nxt   = '0;
              state_nxt = S_CRD;
            end else begin
              edit_len_nxt = '0;
              rec_act_nxt  = 1'b0;
              state_nxt    = echo_r ? S_CR : S_IDLE;
            end
          end else if (erase_r && (in_rx_byte == CH_BS || in_rx_byte == CH_DEL)) begin
            rec_act_nxt = 1'b0;
            if (edit_len_r != '0) begin
              edit_len_nxt = edit_len_r - 1'b1;
              if (echo_r) begin
                hold_kind_nxt = KIND_ERASE;
                hold_data_nxt = CH_NUL;
                hold_cnt_nxt  = 6'd1;
                hold_rdy_nxt  = 1'b0;
                hold_ovf_nxt  = 1'b0;
                hold_last_nxt = 1'b1;
                more_nxt      = 1'b0;
                state_nxt     = S_ONE;
              end
            end
          end else if (edit_len_r != LMAX) begin
            we.edit_we   = 1'b1;
            edit_len_nxt = edit_len_r + 1'b1;
            rec_act_nxt  = 1'b0;
            if (echo_r) begin
              hold_kind_nxt = KIND_ECHO;
              hold_data_nxt = in_rx_byte;
              hold_cnt_nxt  = 6'd0;
              hold_rdy_nxt  = 1'b0;
              hold_ovf_nxt  = 1'b0;
              hold_last_nxt = 1'b1;
              more_nxt      = 1'b0;
              state_nxt     = S_ONE;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      S_ONE: begin
        if (can_emit) begin
          em        = 1'b1;
          em_kind   = hold_kind_r;
          em_data   = hold_data_r;
          em_cnt    = hold_cnt_r;
          em_rdy    = hold_rdy_r;
          em_ovf    = hold_ovf_r;
          em_last   = hold_last_r;
          state_nxt = more_r ? S_TRD : S_IDLE;
        end
      end
      S_CRD: begin
        if (cnt_r == edit_len_r) begin
          taken_len_nxt = cnt_r;
          ready_nxt     = 1'b1;
          edit_len_nxt  = '0;
          rec_act_nxt   = 1'b0;
          state_nxt     = echo_r ? S_CR : S_IDLE;
        end else begin
          state_nxt = S_CWR;
        end
      end
      S_CWR: begin
        wdata = edit_q;
        if (edit_q == CH_NUL) begin
          taken_len_nxt = cnt_r;
          ready_nxt     = 1'b1;
          edit_len_nxt  = '0;
          rec_act_nxt   = 1'b0;
          state_nxt     = echo_r ? S_CR : S_IDLE;
        end else begin
          we.taken_we = 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
          state_nxt   = S_CRD;
        end
      end
      S_CR: begin
        if (can_emit) begin
          em        = 1'b1;
          em_data   = CH_CR;
          state_nxt = S_LF;
        end
      end
      S_LF: begin
        if (can_emit) begin
          em        = 1'b1;
          em_data   = CH_LF;
          em_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RLEN: begin
        rslot     = idx_c;
        idx_nxt   = idx_c;
        state_nxt = S_RERS;
      end
      S_RERS: begin
        if (!(echo_r && old_r != '0) || can_emit) begin
          em           = echo_r && (old_r != '0);
          em_kind      = KIND_ERASE;
          em_cnt       = 6'(old_r);
          em_last      = (len_q == '0);
          edit_len_nxt = len_q;
          lim_nxt      = len_q;
          cnt_nxt      = '0;
          state_nxt    = (len_q == '0) ? S_IDLE : S_RRD;
        end
      end
      S_RRD: begin
        state_nxt = S_REM;
      end
      S_REM: begin
        wdata = hist_q;
        if (!echo_r || can_emit) begin
          we.edit_we = 1'b1;
          em         = echo_r;
          em_data    = hist_q;
          em_last    = (cnt_r == lim_r - 1'b1);
          if (cnt_r == lim_r - 1'b1) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_RRD;
          end
        end
      end
      S_TRD: begin
        state_nxt = S_TEM;
      end
      S_TEM: begin
        wdata = taken_q;
        if (can_emit) begin
          we.hist_we = push_r;
          em         = 1'b1;
          em_kind    = KIND_LINE;
          em_data    = taken_q;
          em_last    = (cnt_r == lim_r - 1'b1);
          if (cnt_r == lim_r - 1'b1) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_TRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      esc_r       <= ESC_NONE;
      edit_len_r  <= '0;
      taken_len_r <= '0;
      ready_r     <= 1'b0;
      ovf_r       <= 1'b0;
      fill_r      <= '0;
      wslot_r     <= '0;
      rec_act_r   <= 1'b0;
      rec_pos_r   <= '0;
      cnt_r       <= '0;
      lim_r       <= '0;
      old_r       <= '0;
      idx_r       <= '0;
      more_r      <= 1'b0;
      push_r      <= 1'b0;
      echo_r      <= 1'b1;
      erase_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      esc_r       <= esc_nxt;
      edit_len_r  <= edit_len_nxt;
      taken_len_r <= taken_len_nxt;
      ready_r     <= ready_nxt;
      ovf_r       <= ovf_nxt;
      fill_r      <= fill_nxt;
      wslot_r     <= wslot_nxt;
      rec_act_r   <= rec_act_nxt;
      rec_pos_r   <= rec_pos_nxt;
      cnt_r       <= cnt_nxt;
      lim_r       <= lim_nxt;
      old_r       <= old_nxt;
      idx_r       <= idx_nxt;
      more_r      <= more_nxt;
      push_r      <= push_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ECHO:  echo_r  <= cfg_data;
          CFG_ERASE: erase_r <= cfg_data;
          default:   echo_r  <= echo_r;
        endcase
      end
      if (em) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_kind_r <= hold_kind_nxt;
    hold_data_r <= hold_data_nxt;
    hold_cnt_r  <= hold_cnt_nxt;
    hold_rdy_r  <= hold_rdy_nxt;
    hold_ovf_r  <= hold_ovf_nxt;
    hold_last_r <= hold_last_nxt;
    if (em) begin
      out_kind_r <= em_kind;
      out_data_r <= em_data;
      out_cnt_r  <= em_cnt;
      out_rdy_r  <= em_rdy;
      out_ovf_r  <= em_ovf;
      out_last_r <= em_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_data_byte     = out_data_r;
  assign out_run_count     = out_cnt_r;
  assign out_line_ready    = out_rdy_r;
  assign out_line_overflow = out_ovf_r;
  assign out_last          = out_last_r;

  a_edit_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    edit_len_r <= LMAX)
    else $error("edit line length beyond limit");

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FMAX)
    else $error("history fill beyond depth");

  a_recall_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    rec_act_r |-> (FW'(rec_pos_r) < fill_r))
    else $error("recall position outside filled history");

  a_emit_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !em)
    else $error("transaction overwrote a stalled result");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the terminal line editor with history ring.
`timescale 1ns / 1ps

module tb;
  import tle_pkg::*;

  localparam int LB = 64;
  localparam int HD = 8;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [5:0] run_count;
    logic       line_ready;
    logic       line_overflow;
    logic       last;
  } editor_result_t;

  typedef struct {
    logic           command;
    logic [7:0]     rx_byte;
    bit             fixed;
    editor_result_t result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_command = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0, cfg_index = 1'b0, cfg_data = 1'b0;
  logic in_stall, out_valid, out_line_ready, out_line_overflow, out_last;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic [5:0] out_run_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  terminal_line_editor_history_unit u_top (.*);

  // editor shadow state
  bit        echo_on, erase_on;
  bit [1:0]  esc_phase;
  bit [7:0]  edit_buf [LB];
  int        edit_len;
  bit [7:0]  taken_buf [LB];
  int        taken_len;
  bit        ready, overflow;
  bit [7:0]  hist_buf [HD][LB];
  int        hist_len [HD];
  int        hist_fill, hist_slot, recall_pos;

  editor_result_t expected_results[$];
  editor_result_t fresh[$];
  int mismatches = 0, results_seen = 0, items_sent = 0;
  bit busy_cfg = 1'b0;

  function automatic void emit(logic [1:0] k, logic [7:0] d, logic [5:0] c,
                               logic r, logic o);
    editor_result_t e;
    e = '{k, d, c, r, o, 1'b0};
    fresh.push_back(e);
  endfunction

  function automatic void emit_erase(int cnt);
    if (echo_on && cnt > 0) emit(KIND_ERASE, 8'h00, cnt[5:0], 1'b0, 1'b0);
  endfunction

  function automatic void emit_echo(logic [7:0] b);
    if (echo_on) emit(KIND_ECHO, b, 6'd0, 1'b0, 1'b0);
  endfunction

  function automatic void load_recall();
    int latest, idx, prev;
    latest = (hist_slot + HD - 1) % HD;
    idx = (latest + HD - recall_pos) % HD;
    prev = edit_len;
    edit_len = hist_len[idx];
    for (int i = 0; i < edit_len; i++) edit_buf[i] = hist_buf[idx][i];
    emit_erase(prev);
    for (int i = 0; i < edit_len; i++) emit_echo(edit_buf[i]);
  endfunction

  function automatic void predict_editor(logic cmd, logic [7:0] ch);
    int n;
    fresh.delete();
    if (cmd != CMD_BYTE) begin
      if (!ready) begin
        emit(KIND_STATUS, 8'h00, 6'd0, 1'b0, overflow);
      end else begin
        emit(KIND_STATUS, 8'h00, taken_len[5:0], 1'b1, overflow);
        for (int i = 0; i < taken_len; i++) emit(KIND_LINE, taken_buf[i], 6'd0, 1'b0, 1'b0);
        ready = 1'b0;
        if (overflow) overflow = 1'b0;
        else if (taken_len > 0) begin
          for (int i = 0; i < taken_len; i++) hist_buf[hist_slot][i] = taken_buf[i];
          hist_len[hist_slot] = taken_len;
          hist_slot = (hist_slot + 1) % HD;
          if (hist_fill < HD) hist_fill++;
          recall_pos = -1;
        end
      end
    end else if (esc_phase == ESC_SEEN) begin
      esc_phase = (ch == CH_CSI) ? ESC_CSI : ESC_NONE;
    end else if (esc_phase == ESC_CSI) begin
      esc_phase = ESC_NONE;
      if (hist_fill > 0 && ch == CH_UP) begin
        if (recall_pos < 0) recall_pos = 0;
        else if (recall_pos < hist_fill - 1) recall_pos++;
        load_recall();
      end else if (hist_fill > 0 && ch == CH_DOWN) begin
        if (recall_pos <= 0) begin
          recall_pos = -1;
          n = edit_len;
          edit_len = 0;
          emit_erase(n);
        end else begin
          recall_pos--;
          load_recall();
        end
      end
    end else if (ch == CH_ESC) begin
      esc_phase = ESC_SEEN;
    end else if (ch == CH_CR || ch == CH_LF) begin
      if (!ready) begin
        n = 0;
        while (n < edit_len && edit_buf[n] != CH_NUL) begin
          taken_buf[n] = edit_buf[n];
          n++;
        end
        taken_len = n;
        ready = 1'b1;
      end
      emit_echo(CH_CR);
      emit_echo(CH_LF);
      edit_len = 0;
      recall_pos = -1;
    end else if (erase_on && (ch == CH_BS || ch == CH_DEL)) begin
      if (edit_len > 0) begin
        edit_len--;
        emit_erase(1);
      end
      recall_pos = -1;
    end else if (edit_len < LB - 1) begin
      edit_buf[edit_len] = ch;
      edit_len++;
      emit_echo(ch);
      recall_pos = -1;
    end else begin
      overflow = 1'b1;
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
  endfunction

  // result checking
  always @(posedge clk) begin
    editor_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_kind, out_data_byte, out_run_count, out_line_ready,
              out_line_overflow, out_last};
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // timeout
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("[terminal_line_editor_history_unit] ERROR");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_item(logic cmd, logic [7:0] b, bit fixed = 0,
                           editor_result_t res = '0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 1) ? $urandom_range(2, 6) : 1) @(posedge clk);
    end
    burst_left--;
    predict_editor(cmd, b);
    if (fixed && (fresh.size() != 1 || fresh[0] != res)) begin
      mismatches++;
      if (mismatches <= 10) $display("directed row %0d disagrees with prediction", items_sent);
    end
    foreach (fresh[i]) expected_results.push_back(fresh[i]);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic write_cfg(logic idx, logic val);
    if (burst_left != 0) in_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ECHO) echo_on = val;
    else erase_on = val;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_BYTE, s[i]);
  endtask

  task automatic random_line();
    int len, r;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_item(CMD_BYTE, CH_BS);
      else if (r == 1) send_item(CMD_BYTE, CH_DEL);
      else if (r == 2) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
      else if (r == 3) begin
        send_item(CMD_BYTE, CH_ESC);
        send_item(CMD_BYTE, ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : CH_CSI);
        send_item(CMD_BYTE, $urandom_range(0, 3) ? ($urandom_range(0, 1) ? CH_UP : CH_DOWN)
                                                   : 8'($urandom_range(0, 255)));
      end else send_item(CMD_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
    end
    if ($urandom_range(0, 5) != 0) send_item(CMD_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
    if ($urandom_range(0, 4) != 0) send_item(CMD_TAKE, 8'h00);
  endtask

  stim_row_t directed[$];

  initial begin
    echo_on = 1; erase_on = 1;
    esc_phase = ESC_NONE; edit_len = 0; taken_len = 0; ready = 0; overflow = 0;
    hist_fill = 0; hist_slot = 0; recall_pos = -1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      '{CMD_TAKE, 8'h00, 1, '{KIND_STATUS, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1}},
      '{CMD_BYTE, CH_BS, 0, '0},
      '{CMD_BYTE, CH_ESC, 0, '0}, '{CMD_BYTE, CH_CSI, 0, '0}, '{CMD_BYTE, CH_UP, 0, '0},
      '{CMD_BYTE, 8'hFF, 1, '{KIND_ECHO, 8'hFF, 6'd0, 1'b0, 1'b0, 1'b1}},
      '{CMD_BYTE, 8'h00, 1, '{KIND_ECHO, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1}},
      '{CMD_BYTE, 8'h41, 0, '0},
      '{CMD_BYTE, CH_DEL, 1, '{KIND_ERASE, 8'h00, 6'd1, 1'b0, 1'b0, 1'b1}},
      '{CMD_BYTE, CH_ESC, 0, '0}, '{CMD_BYTE, 8'h58, 0, '0}, '{CMD_BYTE, 8'h5A, 0, '0},
      '{CMD_BYTE, CH_CR, 0, '0}, '{CMD_BYTE, 8'h31, 0, '0}, '{CMD_BYTE, CH_LF, 0, '0},
      '{CMD_TAKE, 8'h00, 0, '0}, '{CMD_TAKE, 8'h00, 0, '0},
      '{CMD_BYTE, 8'h61, 0, '0}, '{CMD_BYTE, CH_CR, 0, '0}, '{CMD_TAKE, 8'h00, 0, '0},
      '{CMD_BYTE, CH_ESC, 0, '0}, '{CMD_BYTE, CH_CSI, 0, '0}, '{CMD_BYTE, CH_UP, 0, '0},
      '{CMD_BYTE, CH_ESC, 0, '0}, '{CMD_BYTE, CH_CSI, 0, '0}
    };
    foreach (directed[i])
      send_item(directed[i].command, directed[i].rx_byte, directed[i].fixed,
                directed[i].result);
    send_item(CMD_BYTE, CH_DOWN);
    for (int i = 0; i < 66; i++) send_item(CMD_BYTE, 8'(8'h21 + i));
    send_text("\r");
    send_item(CMD_TAKE, 8'h00);
    send_item(CMD_TAKE, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      write_cfg(CFG_ECHO, (phase % 2) == 0);
      write_cfg(CFG_ERASE, phase < 2);
      while (items_sent < 100 + phase * 40) random_line();
    end
    write_cfg(CFG_ECHO, 1'b1);
    write_cfg(CFG_ERASE, 1'b1);
    while (items_sent < 280) random_line();
    send_item(CMD_TAKE, 8'h00);

    if (burst_left != 0) in_valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d input transactions, checked %0d results over four register settings.",
             items_sent, results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[terminal_line_editor_history_unit] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[terminal_line_editor_history_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== terminal_line_editor_history_unit.f =====
rtl/tle_pkg.sv
rtl/tle_store.sv
rtl/terminal_line_editor_history_unit.sv
dv/tb.sv
